FILE: src/gzip_header_parser_top_defines.svh
// Assertion macros shared by the gzip header parser RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GZIP_HEADER_PARSER_TOP_DEFINES_SVH
`define GZIP_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define GZHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GZHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/gzhp_pkg.sv
// Types, constants and helper functions for the gzip member header parser.
// No dependencies.
package gzhp_pkg;

    typedef enum logic [3:0] {
        PH_ID1     = 4'd0,
        PH_ID2     = 4'd1,
        PH_CM      = 4'd2,
        PH_FLG     = 4'd3,
        PH_MTIME   = 4'd4,
        PH_XFL     = 4'd5,
        PH_OS      = 4'd6,
        PH_XLEN    = 4'd7,
        PH_EXTRA   = 4'd8,
        PH_NAME    = 4'd9,
        PH_COMMENT = 4'd10,
        PH_HCRC    = 4'd11,
        PH_DONE    = 4'd12,
        PH_ERR     = 4'd13
    } t_phase;

    localparam logic [7:0]  GZ_ID1       = 8'h1f;
    localparam logic [7:0]  GZ_ID2       = 8'h8b;
    localparam logic [7:0]  GZ_DEFLATE   = 8'h08;
    localparam logic [7:0]  FL_RESERVED  = 8'he0;
    localparam int          FL_BIT_TEXT    = 0;
    localparam int          FL_BIT_HCRC    = 1;
    localparam int          FL_BIT_EXTRA   = 2;
    localparam int          FL_BIT_NAME    = 3;
    localparam int          FL_BIT_COMMENT = 4;
    localparam logic [31:0] CRC_POLY     = 32'hedb88320;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_BAD_ID1  = 3'd2;
    localparam logic [2:0] ST_BAD_ID2  = 3'd3;
    localparam logic [2:0] ST_BAD_CM   = 3'd4;
    localparam logic [2:0] ST_RSV_FLAG = 3'd5;
    localparam logic [2:0] ST_BAD_HCRC = 3'd6;

    typedef struct packed {
        logic [7:0] hdr_byte;
        logic       restart;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic        name_valid;
        logic [7:0]  name_char;
        logic [31:0] mod_time;
        logic        text_flag;
        logic [7:0]  os_code;
        logic [15:0] header_crc;
    } t_result;

    // reflected CRC-32 update by one byte, preset and final inversion
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    // first enabled optional section at or after 'from', else done
    function automatic t_phase pick_next(input t_phase from, input logic [7:0] flags);
        t_phase p;
        if (from <= PH_XLEN && flags[FL_BIT_EXTRA]) begin
            p = PH_XLEN;
        end else if (from <= PH_NAME && flags[FL_BIT_NAME]) begin
            p = PH_NAME;
        end else if (from <= PH_COMMENT && flags[FL_BIT_COMMENT]) begin
            p = PH_COMMENT;
        end else if (from <= PH_HCRC && flags[FL_BIT_HCRC]) begin
            p = PH_HCRC;
        end else begin
            p = PH_DONE;
        end
        return p;
    endfunction

endpackage

FILE: src/gzhp_in_stage.sv
// Input register of the gzip header parser: holds one stream beat.
// Depends on gzhp_pkg.
module gzhp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gzhp_pkg::t_in_beat i_beat,
    output logic              o_valid,
    output gzhp_pkg::t_in_beat o_beat,
    input  logic              i_advance
);
    import gzhp_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

FILE: src/gzhp_core.sv
// Header state machine and running CRC of the gzip header parser.
// Depends on gzhp_pkg and gzip_header_parser_top_defines.svh.
module gzhp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  gzhp_pkg::t_in_beat i_beat,
    output gzhp_pkg::t_result  o_result
);
    import gzhp_pkg::*;
    `include "gzip_header_parser_top_defines.svh"

    t_phase      r_phase, n_phase, c_phase;
    logic [1:0]  r_cnt, n_cnt, c_cnt;
    logic [2:0]  r_err, n_err;
    logic [15:0] r_xlen, n_xlen, c_xlen, xlen_dec;
    logic [7:0]  r_flags, n_flags, c_flags;
    logic [31:0] r_time, n_time, c_time;
    logic [7:0]  r_os, n_os, c_os;
    logic [31:0] r_crc, n_crc, c_crc, crc_upd;
    logic [7:0]  r_chk, n_chk, c_chk;
    logic [7:0]  b;
    logic        name_vld;
    logic [2:0]  status;

    assign b       = i_beat.hdr_byte;
    assign crc_upd = crc32_byte(c_crc, b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_ID1;
            r_cnt   <= 2'd0;
            r_err   <= ST_BUSY;
            r_xlen  <= 16'd0;
            r_flags <= 8'd0;
            r_time  <= 32'd0;
            r_os    <= 8'd0;
            r_crc   <= 32'd0;
            r_chk   <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_xlen  <= n_xlen;
            r_flags <= n_flags;
            r_time  <= n_time;
            r_os    <= n_os;
            r_crc   <= n_crc;
            r_chk   <= n_chk;
        end
    end

    always_comb begin
        // restart beat starts from the reset state
        c_phase = i_beat.restart ? PH_ID1 : r_phase;
        c_cnt   = i_beat.restart ? 2'd0   : r_cnt;
        c_xlen  = i_beat.restart ? 16'd0  : r_xlen;
        c_flags = i_beat.restart ? 8'd0   : r_flags;
        c_time  = i_beat.restart ? 32'd0  : r_time;
        c_os    = i_beat.restart ? 8'd0   : r_os;
        c_crc   = i_beat.restart ? 32'd0  : r_crc;
        c_chk   = i_beat.restart ? 8'd0   : r_chk;

        n_phase  = c_phase;
        n_cnt    = c_cnt;
        n_err    = r_err;
        n_xlen   = c_xlen;
        n_flags  = c_flags;
        n_time   = c_time;
        n_os     = c_os;
        n_crc    = c_crc;
        n_chk    = c_chk;
        name_vld = 1'b0;
        xlen_dec = (c_xlen != 16'd0) ? c_xlen - 16'd1 : 16'd0;

        case (c_phase)
            PH_ID1: begin
                n_crc = crc_upd;
                n_cnt = 2'd0;
                if (b != GZ_ID1) begin
                    n_phase = PH_ERR;
                    n_err   = ST_BAD_ID1;
                end else begin
                    n_phase = PH_ID2;
                end
            end
            PH_ID2: begin
                n_crc = crc_upd;
                n_cnt = 2'd0;
                if (b != GZ_ID2) begin
                    n_phase = PH_ERR;
                    n_err   = ST_BAD_ID2;
                end else begin
                    n_phase = PH_CM;
                end
            end
            PH_CM: begin
                n_crc = crc_upd;
                n_cnt = 2'd0;
                if (b != GZ_DEFLATE) begin
                    n_phase = PH_ERR;
                    n_err   = ST_BAD_CM;
                end else begin
                    n_phase = PH_FLG;
                end
            end
            PH_FLG: begin
                n_crc   = crc_upd;
                n_flags = b;
                n_cnt   = 2'd0;
                if ((b & FL_RESERVED) != 8'd0) begin
                    n_phase = PH_ERR;
                    n_err   = ST_RSV_FLAG;
                end else begin
                    n_phase = PH_MTIME;
                end
            end
            PH_MTIME: begin
                n_crc  = crc_upd;
                n_time = c_time | ({24'd0, b} << {c_cnt, 3'b000});
                n_cnt  = c_cnt + 2'd1;
                if (c_cnt == 2'd3) begin
                    n_phase = PH_XFL;
                end
            end
            PH_XFL: begin
                n_crc   = crc_upd;
                n_cnt   = 2'd0;
                n_phase = PH_OS;
            end
            PH_OS: begin
                n_crc   = crc_upd;
                n_os    = b;
                n_cnt   = 2'd0;
                n_phase = pick_next(PH_XLEN, c_flags);
            end
            PH_XLEN: begin
                n_crc = crc_upd;
                if (c_cnt == 2'd0) begin
                    n_xlen = {8'd0, b};
                    n_cnt  = 2'd1;
                end else begin
                    n_xlen  = {b, c_xlen[7:0]};
                    n_cnt   = 2'd0;
                    n_phase = ({b, c_xlen[7:0]} != 16'd0) ? PH_EXTRA
                                                           : pick_next(PH_NAME, c_flags);
                end
            end
            PH_EXTRA: begin
                n_crc  = crc_upd;
                n_xlen = xlen_dec;
                if (xlen_dec == 16'd0) begin
                    n_cnt   = 2'd0;
                    n_phase = pick_next(PH_NAME, c_flags);
                end
            end
            PH_NAME: begin
                n_crc = crc_upd;
                if (b != 8'd0) begin
                    name_vld = 1'b1;
                end else begin
                    n_cnt   = 2'd0;
                    n_phase = pick_next(PH_COMMENT, c_flags);
                end
            end
            PH_COMMENT: begin
                n_crc = crc_upd;
                if (b == 8'd0) begin
                    n_cnt   = 2'd0;
                    n_phase = pick_next(PH_HCRC, c_flags);
                end
            end
            PH_HCRC: begin
                // check bytes stay out of the CRC
                if (c_cnt == 2'd0) begin
                    n_chk = b;
                    n_cnt = 2'd1;
                end else begin
                    n_cnt = 2'd0;
                    if ({b, c_chk} == c_crc[15:0]) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_ERR;
                        n_err   = ST_BAD_HCRC;
                    end
                end
            end
            default: begin
            end
        endcase

        case (n_phase)
            PH_DONE: status = ST_DONE;
            PH_ERR:  status = n_err;
            default: status = ST_BUSY;
        endcase

        o_result.status     = status;
        o_result.name_valid = name_vld;
        o_result.name_char  = name_vld ? b : 8'd0;
        o_result.mod_time   = n_time;
        o_result.text_flag  = n_flags[FL_BIT_TEXT];
        o_result.os_code    = n_os;
        o_result.header_crc = n_crc[15:0];
    end

    `GZHP_ASSERT_NOW(a_err_code_range, r_phase == PH_ERR,
        r_err == ST_BAD_ID1 || r_err == ST_BAD_ID2 || r_err == ST_BAD_CM ||
        r_err == ST_RSV_FLAG || r_err == ST_BAD_HCRC, "error phase holds a bad code")
    `GZHP_ASSERT_NEXT(a_sticky_end,
        i_fire && !i_beat.restart && (r_phase == PH_DONE || r_phase == PH_ERR),
        $stable(r_crc) && $stable(r_phase), "state moved after done or error")

endmodule

FILE: src/gzhp_out_stage.sv
// Result register of the gzip header parser, output side of the stream.
// Depends on gzhp_pkg.
module gzhp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  gzhp_pkg::t_result i_result,
    output logic              o_advance,
    output logic              o_valid,
    input  logic              i_ready,
    output gzhp_pkg::t_result o_result
);
    import gzhp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: src/gzip_header_parser_top.sv
// Top level of the gzip member header parser: input register, parser core, result register.
// Depends on gzhp_pkg, gzhp_in_stage, gzhp_core, gzhp_out_stage and the defines header.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | [7:0] hdr_byte                          | restart
//  m_axis   | out | [2:0] status, [10:3] name_char,         | name_valid
//           |     | [42:11] mod_time, [43] text_flag,       |
//           |     | [51:44] os_code, [67:52] header_crc     |
//
// One result beat per input beat; a beat can be taken every cycle while m_axis accepts results.
// Each beat passes the input register, then the parser logic into the result register.
// The per-byte CRC-32 step and the header state update sit between the two registers.
// i_rst_n is synchronous; it empties both registers and returns to expecting ID1.
// Backpressure on m_axis stalls the whole pipe; no beat is dropped.
module gzip_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] hdr_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status, name_char, mod_time, text_flag, os_code,
                                        // header_crc, zero pad
    output logic        m_axis_tuser    // [0] name_valid
);
    import gzhp_pkg::*;
    `include "gzip_header_parser_top_defines.svh"

    t_in_beat in_beat, stage_beat;
    t_result  core_result, out_result;
    logic     stage_valid;
    logic     advance;

    assign in_beat.hdr_byte = s_axis_tdata;
    assign in_beat.restart  = s_axis_tuser;

    gzhp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_beat    (in_beat),
        .o_valid   (stage_valid),
        .o_beat    (stage_beat),
        .i_advance (advance)
    );

    gzhp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (stage_valid && advance),
        .i_beat   (stage_beat),
        .o_result (core_result)
    );

    gzhp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_result  (core_result),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (out_result)
    );

    assign m_axis_tdata = {4'd0, out_result.header_crc, out_result.os_code,
                           out_result.text_flag, out_result.mod_time,
                           out_result.name_char, out_result.status};
    assign m_axis_tuser = out_result.name_valid;

    `GZHP_ASSERT_NOW(a_name_while_busy, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[2:0] == ST_BUSY, "name byte with finished status")
    `GZHP_ASSERT_NOW(a_ready_when_out_free, !m_axis_tvalid, s_axis_tready,
        "input stalled while result register is empty")

endmodule
